>>> hdl/mjs_pkg.sv
// ----------------------------------------------------------------------------
// mjs_pkg
// Types and constants shared by the multicore job scheduler modules.
// ----------------------------------------------------------------------------
package mjs_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int MAX_CORES   = 8;
  localparam int CORE_W      = 4;
  localparam logic [CORE_W-1:0] IDLE_CORE = 4'hF;

  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_CORES = 1'b1;

  typedef enum logic [2:0] {
    MODE_FCFS = 3'd0,
    MODE_SJF  = 3'd1,
    MODE_PSJF = 3'd2,
    MODE_PRI  = 3'd3,
    MODE_PPRI = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WR_VIC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [15:0]       job;
    logic [31:0]       arrival;
    logic [15:0]       urgency;
    logic [CORE_W-1:0] core;
    logic              started;
    logic [31:0]       first;
    logic [31:0]       remaining;
    logic [31:0]       last;
    logic [15:0]       length;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    mode_t       mode;
    logic [3:0]  ncores;
  } sched_cfg_t;

  typedef struct packed {
    logic        assigned;
    logic [2:0]  assigned_core;
    logic [15:0] next_job;
    logic        overflow;
    logic [39:0] wait_sum;
    logic [39:0] response_sum;
    logic [39:0] turnaround_sum;
    logic [31:0] jobs_seen;
  } result_t;

  // remaining time less the time already run, floored at zero
  function automatic logic [31:0] adj_remaining(input logic [31:0] rem,
                                                input logic [31:0] last,
                                                input logic [31:0] now);
    logic [31:0] ran;
    ran = (now >= last) ? (now - last) : 32'd0;
    return (rem > ran) ? (rem - ran) : 32'd0;
  endfunction

endpackage

>>> hdl/mjs_ram.sv
// ----------------------------------------------------------------------------
// mjs_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module mjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/mjs_ctrl.sv
// ----------------------------------------------------------------------------
// mjs_ctrl
// Sequencer: scans the job table once per item, then places, evicts or
// retires jobs and updates the running totals.
// ----------------------------------------------------------------------------
module mjs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  mjs_pkg::sched_cfg_t cfg,
  input  logic                start,
  input  logic                func,
  input  logic [15:0]         job_id,
  input  logic [31:0]         now,
  input  logic [15:0]         run_length,
  input  logic [15:0]         job_priority,
  input  logic [2:0]          core_index,
  output logic                busy,
  output logic                res_valid,
  input  logic                res_take,
  output mjs_pkg::result_t    res
);
  import mjs_pkg::*;

  state_t state, state_next;

  logic              func_q;
  logic [15:0]       id_q, len_q, pri_q;
  logic [31:0]       now_q;
  logic [2:0]        core_q;

  logic [CNT_W-1:0]  cnt;
  logic              p_live, p_valid;
  logic [IDX_W-1:0]  p_idx;
  logic [TABLE_DEPTH-1:0] valid;

  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [MAX_CORES-1:0] core_busy;
  logic              v_found, f_found, b_found;
  logic [IDX_W-1:0]  v_idx, f_idx, b_idx;
  logic [63:0]       v_key, b_key;
  slot_t             v_rec, f_rec, b_rec;

  logic [39:0]       wait_total, resp_total, turn_total;
  logic [31:0]       job_count;
  logic              r_assigned, r_overflow;
  logic [2:0]        r_core;
  logic [15:0]       r_next;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  slot_t             wdata, rdata;

  // scan compare terms
  logic              live, on_active;
  logic [63:0]       vkey_c, bkey_c;
  logic [31:0]       vk_hi;

  // decide terms
  logic              placed, evict;
  logic [2:0]        idle_c;
  logic [31:0]       new_key;
  slot_t             new_rec, vic_rec, b_upd;
  logic [32:0]       wd, td;
  logic [33:0]       rd;
  logic [31:0]       wpos, rpos, tpos;
  logic [40:0]       wsum, rsum, tsum;

  mjs_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (cnt == CNT_W'(TABLE_DEPTH) && !p_live) state_next = ST_DECIDE;
      ST_DECIDE: state_next = (func_q == FUNC_ARRIVE && free_found && evict) ?
                              ST_WR_VIC : ST_DONE;
      ST_WR_VIC: state_next = ST_DONE;
      ST_DONE:   if (res_take) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign busy      = (state != ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // scan compare unit
  always_comb begin
    live      = p_live && p_valid;
    on_active = rdata.core < CORE_W'(cfg.ncores);
    vk_hi     = (cfg.mode == MODE_PSJF) ?
                adj_remaining(rdata.remaining, rdata.last, now_q) :
                {16'd0, rdata.urgency};
    vkey_c    = {vk_hi, rdata.arrival};
    priority case (cfg.mode)
      MODE_SJF, MODE_PSJF: bkey_c = {rdata.remaining, rdata.arrival};
      MODE_PRI, MODE_PPRI: bkey_c = {16'd0, rdata.urgency, rdata.arrival};
      default:             bkey_c = {32'd0, rdata.arrival};
    endcase
  end

  // decide logic
  always_comb begin
    placed = 1'b0;
    idle_c = '0;
    for (int c = 0; c < MAX_CORES; c++) begin
      if (!placed && c < int'(cfg.ncores) && !core_busy[c]) begin
        placed = 1'b1;
        idle_c = 3'(c);
      end
    end
    new_key = (cfg.mode == MODE_PSJF) ? {16'd0, len_q} : {16'd0, pri_q};
    evict   = !placed && (cfg.mode == MODE_PSJF || cfg.mode == MODE_PPRI) &&
              v_found && (v_key[63:32] > new_key);

    new_rec.job       = id_q;
    new_rec.arrival   = now_q;
    new_rec.urgency   = pri_q;
    new_rec.core      = placed ? {1'b0, idle_c} : (evict ? v_rec.core : IDLE_CORE);
    new_rec.started   = placed || evict;
    new_rec.first     = (placed || evict) ? now_q : 32'd0;
    new_rec.remaining = {16'd0, len_q};
    new_rec.last      = (placed || evict) ? now_q : 32'd0;
    new_rec.length    = len_q;

    vic_rec           = v_rec;
    vic_rec.remaining = adj_remaining(v_rec.remaining, v_rec.last, now_q);
    vic_rec.core      = IDLE_CORE;
    vic_rec.last      = 32'd0;
    if (v_rec.started && v_rec.first == now_q) begin
      vic_rec.started = 1'b0;
      vic_rec.first   = 32'd0;
    end

    b_upd      = b_rec;
    b_upd.core = {1'b0, core_q};
    b_upd.last = now_q;
    if (!b_rec.started) begin
      b_upd.started = 1'b1;
      b_upd.first   = now_q;
    end

    wd   = {1'b0, f_rec.first} - {1'b0, f_rec.arrival};
    td   = {1'b0, now_q} - {1'b0, f_rec.arrival};
    rd   = {2'b0, now_q} - {18'd0, f_rec.length} - {2'b0, f_rec.arrival};
    wpos = wd[32] ? 32'd0 : wd[31:0];
    tpos = td[32] ? 32'd0 : td[31:0];
    rpos = rd[33] ? 32'd0 : rd[31:0];
    wsum = {1'b0, wait_total} + {9'd0, wpos};
    rsum = {1'b0, resp_total} + {9'd0, rpos};
    tsum = {1'b0, turn_total} + {9'd0, tpos};

    we    = 1'b0;
    waddr = free_idx;
    wdata = new_rec;
    if (state == ST_DECIDE && func_q == FUNC_ARRIVE && free_found) begin
      we = 1'b1;
    end else if (state == ST_WR_VIC) begin
      we    = 1'b1;
      waddr = v_idx;
      wdata = vic_rec;
    end else if (state == ST_DECIDE && func_q == FUNC_FINISH && f_found &&
                 ({1'b0, core_q} < cfg.ncores) && b_found) begin
      we    = 1'b1;
      waddr = b_idx;
      wdata = b_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      wait_total <= '0;
      resp_total <= '0;
      turn_total <= '0;
      job_count  <= '0;
      p_live     <= 1'b0;
      cnt        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            func_q     <= func;
            id_q       <= job_id;
            now_q      <= now;
            len_q      <= run_length;
            pri_q      <= job_priority;
            core_q     <= core_index;
            cnt        <= '0;
            p_live     <= 1'b0;
            free_found <= 1'b0;
            v_found    <= 1'b0;
            f_found    <= 1'b0;
            b_found    <= 1'b0;
            core_busy  <= '0;
            r_assigned <= 1'b0;
            r_overflow <= 1'b0;
            r_core     <= '0;
            r_next     <= '0;
          end
        end
        ST_SCAN: begin
          p_live  <= (cnt != CNT_W'(TABLE_DEPTH));
          p_idx   <= cnt[IDX_W-1:0];
          p_valid <= valid[cnt[IDX_W-1:0]];
          if (cnt != CNT_W'(TABLE_DEPTH)) cnt <= cnt + 1'b1;
          if (p_live && !p_valid && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= p_idx;
          end
          if (live && on_active) begin
            core_busy[rdata.core[2:0]] <= 1'b1;
            if (!v_found || vkey_c > v_key) begin
              v_found <= 1'b1;
              v_idx   <= p_idx;
              v_key   <= vkey_c;
              v_rec   <= rdata;
            end
          end
          if (live && !f_found && rdata.core == {1'b0, core_q}) begin
            f_found <= 1'b1;
            f_idx   <= p_idx;
            f_rec   <= rdata;
          end
          if (live && rdata.core == IDLE_CORE && (!b_found || bkey_c < b_key)) begin
            b_found <= 1'b1;
            b_idx   <= p_idx;
            b_key   <= bkey_c;
            b_rec   <= rdata;
          end
        end
        ST_DECIDE: begin
          if (func_q == FUNC_ARRIVE) begin
            if (!free_found) begin
              r_overflow <= 1'b1;
            end else begin
              valid[free_idx] <= 1'b1;
              if (job_count != '1) job_count <= job_count + 1'b1;
              r_assigned <= placed || evict;
              r_core     <= placed ? idle_c : (evict ? v_rec.core[2:0] : 3'd0);
            end
          end else if (f_found) begin
            wait_total   <= wsum[40] ? '1 : wsum[39:0];
            resp_total   <= rsum[40] ? '1 : rsum[39:0];
            turn_total   <= tsum[40] ? '1 : tsum[39:0];
            valid[f_idx] <= 1'b0;
            if (({1'b0, core_q} < cfg.ncores) && b_found) begin
              r_assigned <= 1'b1;
              r_core     <= core_q;
              r_next     <= b_rec.job;
            end
          end
        end
        ST_WR_VIC: ;
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    res.assigned       = r_assigned;
    res.assigned_core  = r_core;
    res.next_job       = r_next;
    res.overflow       = r_overflow;
    res.wait_sum       = wait_total;
    res.response_sum   = resp_total;
    res.turnaround_sum = turn_total;
    res.jobs_seen      = job_count;
  end

endmodule

>>> hdl/multicore_job_scheduler_unit.sv
// Each item: the table is read slot by slot through the single read port,
// then the new or updated slot is written and, on an eviction, the victim.
// One item at a time: in_stall is high while an item is in work. The result
// register lets the next item enter while a result waits in it.
// Reset (rst, synchronous): table empty, totals and counts zero, mode fcfs,
// one active core. No clearing pass is needed.
// ----------------------------------------------------------------------------
// multicore_job_scheduler_unit
// Top level: configuration registers, sequencer and result register.
// ----------------------------------------------------------------------------
module multicore_job_scheduler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [15:0] job_id,
  input  logic [31:0] now,
  input  logic [15:0] run_length,
  input  logic [15:0] job_priority,
  input  logic [2:0]  core_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        assigned,
  output logic [2:0]  assigned_core,
  output logic [15:0] next_job,
  output logic        overflow,
  output logic [39:0] wait_sum,
  output logic [39:0] response_sum,
  output logic [39:0] turnaround_sum,
  output logic [31:0] jobs_seen
);
  import mjs_pkg::*;

  logic [2:0] mode_reg;
  logic [3:0] cores_reg;
  sched_cfg_t cfg;
  logic       busy, res_valid, res_take;
  result_t    res, out_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg  <= 3'd0;
      cores_reg <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MODE) mode_reg <= cfg_data[2:0];
      else cores_reg <= cfg_data;
    end
  end

  always_comb begin
    cfg.mode = (mode_reg > 3'd4) ? MODE_FCFS : mode_t'(mode_reg);
    if (cores_reg == 4'd0)                  cfg.ncores = 4'd1;
    else if (cores_reg > 4'(MAX_CORES))     cfg.ncores = 4'(MAX_CORES);
    else                                    cfg.ncores = cores_reg;
  end

  assign in_stall = busy;
  assign res_take = res_valid && (!out_valid || !out_stall);

  mjs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (in_valid && !in_stall),
    .func         (func),
    .job_id       (job_id),
    .now          (now),
    .run_length   (run_length),
    .job_priority (job_priority),
    .core_index   (core_index),
    .busy         (busy),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_q <= res;
  end

  assign assigned       = out_q.assigned;
  assign assigned_core  = out_q.assigned_core;
  assign next_job       = out_q.next_job;
  assign overflow       = out_q.overflow;
  assign wait_sum       = out_q.wait_sum;
  assign response_sum   = out_q.response_sum;
  assign turnaround_sum = out_q.turnaround_sum;
  assign jobs_seen      = out_q.jobs_seen;

endmodule

>>> hdl/mjs_checker.sv
// ----------------------------------------------------------------------------
// mjs_checker
// Port-level checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mjs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        assigned,
  input logic [2:0]  assigned_core,
  input logic [15:0] next_job,
  input logic        overflow
);

  // a dropped job is never placed
  a_ovf_not_assigned: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> !assigned && next_job == 16'd0)
    else $error("overflow with assignment");

  // unassigned results carry no core and no job
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !assigned |-> assigned_core == 3'd0 && next_job == 16'd0)
    else $error("stray fields on unassigned result");

  // an accepted item keeps the input side stalled next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a stalled result item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(assigned) &&
      $stable(assigned_core) && $stable(next_job) && $stable(overflow))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multicore_job_scheduler_unit mjs_checker u_mjs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .assigned      (assigned),
  .assigned_core (assigned_core),
  .next_job      (next_job),
  .overflow      (overflow)
);

>>> tb/sv/multicore_job_scheduler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multicore_job_scheduler_unit_tb
// Self-checking bench: drives arrival and finish events under several mode
// and core-count settings, predicts every result and checks each field.
// ----------------------------------------------------------------------------
module multicore_job_scheduler_unit_tb;
  import mjs_pkg::*;

  localparam logic [2:0] MODE_RSVD_LO = 3'd5;
  localparam logic [2:0] MODE_RSVD_HI = 3'd7;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic        func;
    logic [15:0] id;
    logic [31:0] t;
    logic [15:0] len;
    logic [15:0] pri;
    logic [2:0]  core;
  } sched_evt_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_MODE;
  logic [3:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = FUNC_ARRIVE;
  logic [15:0] job_id = '0;
  logic [31:0] now = '0;
  logic [15:0] run_length = '0;
  logic [15:0] job_priority = '0;
  logic [2:0]  core_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        assigned;
  logic [2:0]  assigned_core;
  logic [15:0] next_job;
  logic        overflow;
  logic [39:0] wait_sum, response_sum, turnaround_sum;
  logic [31:0] jobs_seen;

  multicore_job_scheduler_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler state as predicted
  logic [2:0]  mode_q;
  logic [3:0]  cores_q;
  logic        tbl_used [TABLE_DEPTH];
  slot_t       tbl [TABLE_DEPTH];
  logic [39:0] wait_acc, resp_acc, turn_acc;
  logic [31:0] accepted_jobs;

  sched_evt_t  pending_events[$];
  result_t     expected_results[$];
  int          mismatches = 0;
  int          items_in = 0;
  logic        in_taken = 1'b0;
  logic        calm = 1'b0;
  int          idle_cycles = 0;

  function automatic logic [31:0] left_to_run(int s, logic [31:0] t);
    logic [31:0] ran;
    ran = (t >= tbl[s].last) ? t - tbl[s].last : 32'd0;
    return (tbl[s].remaining > ran) ? tbl[s].remaining - ran : 32'd0;
  endfunction

  function automatic logic [39:0] add_sat(logic [39:0] a, longint d);
    logic [40:0] s;
    s = {1'b0, a} + ((d > 0) ? d[40:0] : 41'd0);
    return s[40] ? '1 : s[39:0];
  endfunction

  function automatic void place(int s, logic [3:0] c, logic [31:0] t);
    tbl[s].core = c;
    tbl[s].last = t;
    if (!tbl[s].started) begin
      tbl[s].started = 1'b1;
      tbl[s].first = t;
    end
  endfunction

  function automatic int job_on_core(logic [3:0] c);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (tbl_used[i] && tbl[i].core == c) return i;
    return -1;
  endfunction

  function automatic result_t schedule_event(sched_evt_t e);
    result_t r;
    logic [2:0] m;
    int n, s, v, b;
    logic [63:0] k, best;
    logic [3:0] vc;
    r = '0;
    m = (mode_q > 3'd4) ? MODE_FCFS : mode_q;
    n = (cores_q == 0) ? 1 : (cores_q > MAX_CORES) ? MAX_CORES : int'(cores_q);
    s = -1; v = -1; b = -1; best = '0;
    if (e.func == FUNC_ARRIVE) begin
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (!tbl_used[i] && s < 0) s = i;
      if (s < 0) begin
        r.overflow = 1'b1;
      end else begin
        tbl_used[s] = 1'b1;
        tbl[s] = '0;
        tbl[s].job = e.id;
        tbl[s].arrival = e.t;
        tbl[s].urgency = e.pri;
        tbl[s].core = IDLE_CORE;
        tbl[s].remaining = {16'd0, e.len};
        tbl[s].length = e.len;
        if (accepted_jobs != '1) accepted_jobs++;
        for (int c = 0; c < n && !r.assigned; c++) begin
          if (job_on_core(4'(c)) < 0) begin
            place(s, 4'(c), e.t);
            r.assigned = 1'b1;
            r.assigned_core = 3'(c);
          end
        end
        if (!r.assigned && (m == MODE_PSJF || m == MODE_PPRI)) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!tbl_used[i] || tbl[i].core == IDLE_CORE || tbl[i].core >= n) continue;
            k[63:32] = (m == MODE_PSJF) ? left_to_run(i, e.t) : {16'd0, tbl[i].urgency};
            k[31:0] = tbl[i].arrival;
            if (v < 0 || k > best) begin
              v = i;
              best = k;
            end
          end
          if (v >= 0 && best[63:32] > ((m == MODE_PSJF) ? {16'd0, e.len} : {16'd0, e.pri}))
          begin
            vc = tbl[v].core;
            tbl[v].remaining = left_to_run(v, e.t);
            tbl[v].core = IDLE_CORE;
            if (tbl[v].started && tbl[v].first == e.t) begin
              tbl[v].started = 1'b0;
              tbl[v].first = '0;
            end
            tbl[v].last = '0;
            place(s, vc, e.t);
            r.assigned = 1'b1;
            r.assigned_core = vc[2:0];
          end
        end
      end
    end else begin
      s = job_on_core({1'b0, e.core});
      if (s >= 0) begin
        wait_acc = add_sat(wait_acc, longint'(tbl[s].first) - longint'(tbl[s].arrival));
        resp_acc = add_sat(resp_acc, longint'(e.t) - longint'(tbl[s].length)
                                     - longint'(tbl[s].arrival));
        turn_acc = add_sat(turn_acc, longint'(e.t) - longint'(tbl[s].arrival));
        tbl_used[s] = 1'b0;
        if (e.core < n) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!tbl_used[i] || tbl[i].core != IDLE_CORE) continue;
            if (m == MODE_SJF || m == MODE_PSJF) k = {tbl[i].remaining, tbl[i].arrival};
            else if (m == MODE_PRI || m == MODE_PPRI)
              k = {16'd0, tbl[i].urgency, tbl[i].arrival};
            else k = {32'd0, tbl[i].arrival};
            if (b < 0 || k < best) begin
              b = i;
              best = k;
            end
          end
          if (b >= 0) begin
            place(b, {1'b0, e.core}, e.t);
            r.assigned = 1'b1;
            r.assigned_core = e.core;
            r.next_job = tbl[b].job;
          end
        end
      end
    end
    r.wait_sum = wait_acc;
    r.response_sum = resp_acc;
    r.turnaround_sum = turn_acc;
    r.jobs_seen = accepted_jobs;
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    sched_evt_t e;
    if (!rst && (!in_valid || in_taken)) begin
      if (pending_events.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
        e = pending_events.pop_front();
        in_valid <= 1'b1;
        func <= e.func;
        job_id <= e.id;
        now <= e.t;
        run_length <= e.len;
        job_priority <= e.pri;
        core_index <= e.core;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // input side: predict on accept
  always @(posedge clk) begin
    sched_evt_t e;
    in_taken <= in_valid && !in_stall && !rst;
    if (!rst && in_valid && !in_stall) begin
      e = '{func, job_id, now, run_length, job_priority, core_index};
      expected_results.push_back(schedule_event(e));
      items_in++;
    end
  end

  // receiver stall, with one long hold-off to back the block up
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && items_in >= 150) begin
      hold_done = 1'b1;
      hold_left = 500;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 7);
    end
  end

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h at %0t", name, exp, act, $realtime);
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    result_t x;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        x = expected_results.pop_front();
        check_field("assigned", 64'(x.assigned), 64'(assigned));
        check_field("assigned_core", 64'(x.assigned_core), 64'(assigned_core));
        check_field("next_job", 64'(x.next_job), 64'(next_job));
        check_field("overflow", 64'(x.overflow), 64'(overflow));
        check_field("wait_sum", 64'(x.wait_sum), 64'(wait_sum));
        check_field("response_sum", 64'(x.response_sum), 64'(response_sum));
        check_field("turnaround_sum", 64'(x.turnaround_sum), 64'(turnaround_sum));
        check_field("jobs_seen", 64'(x.jobs_seen), 64'(jobs_seen));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  logic [31:0] sim_t = 32'd100;

  function automatic void push_evt(logic f, logic [15:0] id, logic [31:0] t, logic [15:0] len,
                                   logic [15:0] pri, logic [2:0] c);
    sched_evt_t e;
    e = '{f, id, t, len, pri, c};
    pending_events.push_back(e);
  endfunction

  task automatic add_random(int count, int arrive_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 3) sim_t = $urandom();
      else if (r < 6) sim_t = sim_t - $urandom_range(0, 200);
      else sim_t = sim_t + $urandom_range(0, 40);
      push_evt(($urandom_range(99) < arrive_pct) ? FUNC_ARRIVE : FUNC_FINISH,
               16'($urandom_range(0, 65535)), sim_t,
               16'($urandom_range(1) ? $urandom_range(0, 65535) : $urandom_range(0, 60)),
               16'($urandom_range(1) ? $urandom_range(0, 65535) : $urandom_range(0, 3)),
               3'($urandom_range(0, 7)));
    end
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_MODE) mode_q = val[2:0];
    else cores_q = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_events.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic phase(logic [2:0] m, logic [3:0] c);
    drain();
    write_reg(CFG_MODE, {1'b0, m});
    write_reg(CFG_CORES, c);
  endtask

  initial begin
    mode_q = MODE_FCFS;
    cores_q = 4'd1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_used[i] = 1'b0;
      tbl[i] = '0;
    end
    wait_acc = '0; resp_acc = '0; turn_acc = '0; accepted_jobs = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, eviction, same-time eviction, empty core, backwards time
    write_reg(CFG_MODE, {1'b0, MODE_PSJF});
    write_reg(CFG_CORES, 4'd2);
    push_evt(FUNC_ARRIVE, 16'h0000, 32'd0, 16'd0, 16'd0, 3'd0);
    push_evt(FUNC_ARRIVE, 16'hFFFF, 32'd10, 16'hFFFF, 16'hFFFF, 3'd7);
    push_evt(FUNC_ARRIVE, 16'd5, 32'd20, 16'd100, 16'd3, 3'd0);
    push_evt(FUNC_ARRIVE, 16'd6, 32'd20, 16'd50, 16'd3, 3'd0);
    push_evt(FUNC_ARRIVE, 16'd7, 32'd20, 16'd100, 16'd3, 3'd0);
    push_evt(FUNC_FINISH, 16'd0, 32'd30, 16'd0, 16'd0, 3'd1);
    push_evt(FUNC_FINISH, 16'd0, 32'd35, 16'd0, 16'd0, 3'd5);
    push_evt(FUNC_FINISH, 16'd0, 32'd2, 16'd0, 16'd0, 3'd0);
    push_evt(FUNC_ARRIVE, 16'h1234, 32'hFFFF_FFFF, 16'd1, 16'hFFFF, 3'd0);
    push_evt(FUNC_FINISH, 16'd0, 32'hFFFF_FFFF, 16'd0, 16'd0, 3'd1);
    push_evt(FUNC_FINISH, 16'd0, 32'hFFFF_FFFF, 16'd0, 16'd0, 3'd0);
    push_evt(FUNC_FINISH, 16'd0, 32'd0, 16'd0, 16'd0, 3'd1);
    phase(MODE_PPRI, 4'd1);
    push_evt(FUNC_ARRIVE, 16'd9, 32'd500, 16'd8, 16'd9, 3'd0);
    push_evt(FUNC_ARRIVE, 16'd10, 32'd500, 16'd8, 16'd2, 3'd0);
    push_evt(FUNC_ARRIVE, 16'd11, 32'd501, 16'd8, 16'd2, 3'd0);
    push_evt(FUNC_FINISH, 16'd0, 32'd600, 16'd0, 16'd0, 3'd0);
    push_evt(FUNC_FINISH, 16'd0, 32'd700, 16'd0, 16'd0, 3'd0);

    // table overflow
    phase(MODE_FCFS, 4'd1);
    add_random(70, 100);
    for (int i = 0; i < 10; i++)
      push_evt(FUNC_FINISH, 16'd0, sim_t + 32'(i), 16'd0, 16'd0, 3'd0);

    phase(MODE_SJF, 4'd8);
    calm = 1'b1;
    add_random(60, 50);
    phase(MODE_PSJF, 4'd8);
    add_random(60, 55);
    drain();
    calm = 1'b0;
    phase(MODE_PPRI, 4'd3);
    add_random(60, 55);
    phase(MODE_PRI, 4'd1);
    add_random(50, 45);
    phase(MODE_RSVD_LO, 4'd0);
    add_random(50, 50);
    phase(MODE_PSJF, 4'd15);
    add_random(60, 55);
    phase(MODE_PPRI, 4'd8);
    add_random(60, 50);
    phase(MODE_RSVD_HI, 4'd2);
    add_random(50, 40);
    phase(MODE_FCFS, 4'd4);
    add_random(40, 50);

    drain();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
hdl/mjs_pkg.sv
hdl/mjs_ram.sv
hdl/mjs_ctrl.sv
hdl/multicore_job_scheduler_unit.sv
hdl/mjs_checker.sv
tb/sv/multicore_job_scheduler_unit_tb.sv
